[rtl/core/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_PAGES  = 1024;
   localparam int PAGE_W     = 10;
   localparam int PTR_W      = PAGE_W + 1;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_W     = 22;
   localparam int RANK_W     = 5;
   localparam int RIDX_W     = 4;
   localparam int NUM_RANKS  = 16;
   localparam int CNT_W      = 11;
   localparam int CMD_W      = 3;
   localparam int STAT_W     = 2;

   localparam logic [PTR_W-1:0]  NIL            = '1;
   localparam logic [RANK_W-1:0] RANK_LIMIT     = 5'd16;
   localparam logic [CNT_W-1:0]  PAGES_RESET    = 11'd1024;
   localparam logic [RANK_W-1:0] TOP_RANK_RESET = 5'd11;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESTART = 3'd0,
      CMD_ALLOC   = 3'd1,
      CMD_RETURN  = 3'd2,
      CMD_QRANK   = 3'd3,
      CMD_QCOUNT  = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_NOSPACE = 2'd2
   } status_type;

   typedef struct packed {
      logic                valid;
      logic [STAT_W-1:0]   status;
      logic [ADDR_W-1:0]   baddr;
      logic [CNT_W-1:0]    value;
   } res_type;

endpackage

[rtl/core/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int DATA_W = 8,
   parameter int AW     = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [(1 << AW)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Command sequencer: list heads, link and rank memories, list walker.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CMD_W-1:0]  in_cmd,
   input  logic [RANK_W-1:0] in_rank,
   input  logic [ADDR_W-1:0] in_addr,
   input  logic [CNT_W-1:0]  page_count,
   input  logic              slot_free,
   output res_type           res
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CLEAR = 10'b0000000010,
      S_DISP  = 10'b0000000100,
      S_AR    = 10'b0000001000,
      S_POP   = 10'b0000010000,
      S_SPLIT = 10'b0000100000,
      S_WALK  = 10'b0001000000,
      S_WAIT  = 10'b0010000000,
      S_PUSH  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [PAGE_W-1:0]    pg_ff, pg_in;
   logic [RANK_W-1:0]    r_ff, r_in;
   logic [PAGE_W-1:0]    blk_ff, blk_in;
   logic [PTR_W-1:0]     cur_ff, cur_in;
   logic [PTR_W-1:0]     prev_ff, prev_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PAGE_W-1:0]    clr_ff, clr_in;
   logic                 boot_ff, boot_in;
   logic [RANK_W-1:0]    top_ff, top_in;
   logic [CNT_W-1:0]     pool_ff, pool_in;
   logic [PTR_W-1:0]     head_ff [NUM_RANKS];
   logic [PTR_W-1:0]     head_in [NUM_RANKS];
   logic [STAT_W-1:0]    status_ff, status_in;
   logic [ADDR_W-1:0]    baddr_ff, baddr_in;
   logic [CNT_W-1:0]     value_ff, value_in;

   logic                 nf_we, nf_re;
   logic [PAGE_W-1:0]    nf_wa, nf_ra;
   logic [PTR_W-1:0]     nf_wd, nf_rd;
   logic                 ar_we, ar_re;
   logic [PAGE_W-1:0]    ar_wa, ar_ra;
   logic [RANK_W-1:0]    ar_wd, ar_rd;

   logic [CNT_W-1:0]     n_pages;
   logic [RANK_W-1:0]    new_top;
   logic                 rank_ok, aligned, found;
   logic [RIDX_W-1:0]    fidx;
   logic [RIDX_W-1:0]    hidx;
   logic [CNT_W-1:0]     span_r, span_lo, diff;
   logic [PAGE_W-1:0]    bud, page_of_addr, split_pg;
   logic [RANK_W-1:0]    r_next;

   bpa_ram #(.DATA_W(PTR_W), .AW(PAGE_W)) u_next_free (
      .clock(clock), .wr_en(nf_we), .wr_addr(nf_wa), .wr_data(nf_wd),
      .rd_en(nf_re), .rd_addr(nf_ra), .rd_data(nf_rd)
   );

   bpa_ram #(.DATA_W(RANK_W), .AW(PAGE_W)) u_alloc_rank (
      .clock(clock), .wr_en(ar_we), .wr_addr(ar_wa), .wr_data(ar_wd),
      .rd_en(ar_re), .rd_addr(ar_ra), .rd_data(ar_rd)
   );

   always_comb begin
      n_pages = (page_count > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count;
      new_top = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (n_pages[i]) begin
            new_top = RANK_W'(i + 1);
         end
      end
      rank_ok      = (rank_ff != '0) && (rank_ff <= RANK_LIMIT);
      page_of_addr = addr_ff[PAGE_SHIFT +: PAGE_W];
      aligned      = (addr_ff[PAGE_SHIFT-1:0] == '0);
      found        = 1'b0;
      fidx         = '0;
      for (int i = NUM_RANKS - 1; i >= 0; i--) begin
         if (!head_ff[i][PTR_W-1] && (RANK_W'(i + 1) >= rank_ff) &&
             (RANK_W'(i + 1) <= top_ff)) begin
            found = 1'b1;
            fidx  = RIDX_W'(i);
         end
      end
      hidx     = RIDX_W'(r_ff - 5'd1);
      span_r   = CNT_W'(1) << (r_ff - 5'd1);
      span_lo  = CNT_W'(1) << (r_ff - 5'd2);
      bud      = pg_ff ^ span_r[PAGE_W-1:0];
      split_pg = blk_ff + span_lo[PAGE_W-1:0];
      diff     = {1'b0, pg_ff} - cur_ff;
      r_next   = r_ff + 5'd1;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      rank_in   = rank_ff;
      addr_in   = addr_ff;
      pg_in     = pg_ff;
      r_in      = r_ff;
      blk_in    = blk_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      boot_in   = boot_ff;
      top_in    = top_ff;
      pool_in   = pool_ff;
      head_in   = head_ff;
      status_in = status_ff;
      baddr_in  = baddr_ff;
      value_in  = value_ff;
      nf_we = 1'b0; nf_wa = '0; nf_wd = '0; nf_re = 1'b0; nf_ra = '0;
      ar_we = 1'b0; ar_wa = '0; ar_wd = '0; ar_re = 1'b0; ar_ra = '0;
      in_ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd_in   = in_cmd;
               rank_in  = in_rank;
               addr_in  = in_addr;
               state_in = S_DISP;
            end
         end
         S_CLEAR: begin
            ar_we = 1'b1;
            ar_wa = clr_ff;
            if (clr_ff == '0) begin
               nf_we = 1'b1;
               nf_wd = NIL;
            end
            clr_in = clr_ff + PAGE_W'(1);
            if (clr_ff == '1) begin
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end
            end
         end
         S_DISP: begin
            status_in = ST_INVALID;
            baddr_in  = '0;
            value_in  = '0;
            pg_in     = page_of_addr;
            state_in  = S_DONE;
            case (cmd_ff)
               CMD_RESTART: begin
                  if (page_count != '0) begin
                     pool_in = n_pages;
                     top_in  = new_top;
                     for (int i = 0; i < NUM_RANKS; i++) begin
                        head_in[i] = NIL;
                     end
                     head_in[RIDX_W'(new_top - 5'd1)] = '0;
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
               end
               CMD_ALLOC: begin
                  if (rank_ok) begin
                     status_in = ST_NOSPACE;
                     if (found) begin
                        r_in     = RANK_W'(fidx) + 5'd1;
                        blk_in   = head_ff[fidx][PAGE_W-1:0];
                        nf_re    = 1'b1;
                        nf_ra    = head_ff[fidx][PAGE_W-1:0];
                        state_in = S_POP;
                     end
                  end
               end
               CMD_RETURN: begin
                  if (aligned) begin
                     ar_re    = 1'b1;
                     ar_ra    = page_of_addr;
                     state_in = S_AR;
                  end
               end
               CMD_QRANK: begin
                  if (aligned && ({1'b0, page_of_addr} < pool_ff)) begin
                     ar_re    = 1'b1;
                     ar_ra    = page_of_addr;
                     state_in = S_AR;
                  end
               end
               CMD_QCOUNT: begin
                  if (rank_ok) begin
                     cur_in   = head_ff[RIDX_W'(rank_ff - 5'd1)];
                     cnt_in   = '0;
                     state_in = S_WALK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_AR: begin
            state_in = S_DONE;
            if (cmd_ff == CMD_RETURN) begin
               if (ar_rd != '0) begin
                  ar_we   = 1'b1;
                  ar_wa   = pg_ff;
                  r_in    = ar_rd;
                  if ((ar_rd < top_ff) && (ar_rd < RANK_LIMIT)) begin
                     cur_in   = head_ff[RIDX_W'(ar_rd - 5'd1)];
                     prev_in  = NIL;
                     state_in = S_WALK;
                  end else begin
                     state_in = S_PUSH;
                  end
               end
            end else begin
               if (ar_rd != '0) begin
                  value_in  = CNT_W'(ar_rd);
                  status_in = ST_OK;
               end else begin
                  r_in     = top_ff;
                  cur_in   = head_ff[RIDX_W'(top_ff - 5'd1)];
                  state_in = S_WALK;
               end
            end
         end
         S_POP: begin
            head_in[hidx] = nf_rd;
            state_in      = S_SPLIT;
         end
         S_SPLIT: begin
            if (r_ff > rank_ff) begin
               nf_we = 1'b1;
               nf_wa = split_pg;
               nf_wd = head_ff[RIDX_W'(r_ff - 5'd2)];
               head_in[RIDX_W'(r_ff - 5'd2)] = {1'b0, split_pg};
               r_in  = r_ff - 5'd1;
            end else begin
               ar_we     = 1'b1;
               ar_wa     = blk_ff;
               ar_wd     = rank_ff;
               baddr_in  = {blk_ff, PAGE_SHIFT'(0)};
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end
         S_WALK: begin
            case (cmd_ff)
               CMD_RETURN: begin
                  if (cur_ff[PTR_W-1]) begin
                     state_in = S_PUSH;
                  end else begin
                     nf_re    = 1'b1;
                     nf_ra    = cur_ff[PAGE_W-1:0];
                     state_in = S_WAIT;
                  end
               end
               CMD_QRANK: begin
                  if (cur_ff[PTR_W-1]) begin
                     if (r_ff == 5'd1) begin
                        state_in = S_DONE;
                     end else begin
                        r_in   = r_ff - 5'd1;
                        cur_in = head_ff[RIDX_W'(r_ff - 5'd2)];
                     end
                  end else if (({1'b0, pg_ff} >= cur_ff) && (diff < span_r)) begin
                     value_in  = CNT_W'(r_ff);
                     status_in = ST_OK;
                     state_in  = S_DONE;
                  end else begin
                     nf_re    = 1'b1;
                     nf_ra    = cur_ff[PAGE_W-1:0];
                     state_in = S_WAIT;
                  end
               end
               CMD_QCOUNT: begin
                  if (cur_ff[PTR_W-1]) begin
                     value_in  = cnt_ff;
                     status_in = ST_OK;
                     state_in  = S_DONE;
                  end else begin
                     cnt_in   = cnt_ff + CNT_W'(1);
                     nf_re    = 1'b1;
                     nf_ra    = cur_ff[PAGE_W-1:0];
                     state_in = S_WAIT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WAIT: begin
            if ((cmd_ff == CMD_RETURN) && (cur_ff[PAGE_W-1:0] == bud)) begin
               if (prev_ff[PTR_W-1]) begin
                  head_in[hidx] = nf_rd;
               end else begin
                  nf_we = 1'b1;
                  nf_wa = prev_ff[PAGE_W-1:0];
                  nf_wd = nf_rd;
               end
               pg_in = (bud < pg_ff) ? bud : pg_ff;
               r_in  = r_next;
               if ((r_next < top_ff) && (r_next < RANK_LIMIT)) begin
                  cur_in   = head_ff[RIDX_W'(r_ff)];
                  prev_in  = NIL;
                  state_in = S_WALK;
               end else begin
                  state_in = S_PUSH;
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = nf_rd;
               state_in = S_WALK;
            end
         end
         S_PUSH: begin
            nf_we         = 1'b1;
            nf_wa         = pg_ff;
            nf_wd         = head_ff[hidx];
            head_in[hidx] = {1'b0, pg_ff};
            status_in     = ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         boot_ff  <= 1'b1;
         top_ff   <= TOP_RANK_RESET;
         pool_ff  <= PAGES_RESET;
         for (int i = 0; i < NUM_RANKS; i++) begin
            head_ff[i] <= (i == int'(TOP_RANK_RESET) - 1) ? PTR_W'(0) : NIL;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         boot_ff  <= boot_in;
         top_ff   <= top_in;
         pool_ff  <= pool_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      rank_ff   <= rank_in;
      addr_ff   <= addr_in;
      pg_ff     <= pg_in;
      r_ff      <= r_in;
      blk_ff    <= blk_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      baddr_ff  <= baddr_in;
      value_ff  <= value_in;
   end

   assign res.valid  = (state_ff == S_DONE);
   assign res.status = status_ff;
   assign res.baddr  = baddr_ff;
   assign res.value  = value_ff;

endmodule

[rtl/core/buddy_page_allocator_unit.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator over a pool of 4 KiB pages with stream ports.
// ----------------------------------------------------------------------------
// channel   direction  fields (lsb first)
// req_*     in         command[2:0] rank[7:3] address[29:8]
// rsp_*     out        status[1:0] block_address[23:2] value[34:24]
// csr_*     in         page_count[10:0]
//
// restart sweeps the alloc rank memory, one page a cycle
// allocate pops a free block and splits it down one rank at a time
// returns and queries walk free lists through the link memory, and a
// rank query of a free page steps down through the empty ranks
// after reset a sweep of the alloc rank memory runs before the first transaction is taken
// a waiting response holds the next result, not the next request
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // command, rank, address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status, block_address, value
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data  // page_count
);

   logic [CNT_W-1:0]  page_count_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [34:0]       rsp_data_ff, rsp_data_in;
   logic              slot_free;
   res_type           res;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   bpa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(req_tdata[2:0]), .in_rank(req_tdata[7:3]), .in_addr(req_tdata[29:8]),
      .page_count(page_count_ff), .slot_free(slot_free), .res(res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = res.valid;
         if (res.valid) begin
            rsp_data_in = {res.value, res.baddr, res.status};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PAGES_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            page_count_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule

[rtl/core/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the buddy page allocator.
// ----------------------------------------------------------------------------
module bpa_checker import bpa_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[34:2] == '0)
      else $error("failed transaction carries data");

   a_page_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:2] == '0)
      else $error("block address not page aligned");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buddy page allocator: a directed table of
// expected replies, then random allocate/return/query traffic across pool
// sizes, idling on both stream sides, checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
   import bpa_pkg::*;

   typedef struct {
      logic [2:0]  cmd;
      logic [4:0]  rank;
      logic [21:0] addr;
      bit          typed;
      status_type  st;
      logic [21:0] baddr;
      logic [10:0] value;
   } step_row_type;

   typedef struct {
      status_type  st;
      logic [21:0] baddr;
      logic [10:0] value;
   } alloc_reply_type;

   localparam int NONE = -1;
   localparam int CYCLE_LIMIT = 4000000;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;

   buddy_page_allocator_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // allocator shadow state
   int free_head[1:16];
   int link_of[0:1023];
   int owner_rank[0:1023];
   int top_r, pool_n, pages_cfg;

   alloc_reply_type pending_replies[$];
   int              live_addrs[$];
   int              mismatches, replies_seen, cycles;
   int              tx_idle_pct, rx_idle_pct;
   int              n_restart, n_alloc_ok, n_return_ok;

   function automatic int span_of(int r);
      return 1 << (r - 1);
   endfunction

   function automatic void push_free(int r, int pg);
      if (pg >= MAX_PAGES) return;
      link_of[pg] = free_head[r];
      free_head[r] = pg;
   endfunction

   function automatic bit unlink_free(int r, int pg);
      int prev, cur, n;
      prev = NONE;
      cur = free_head[r];
      n = 0;
      while (cur >= 0 && cur < MAX_PAGES && n <= MAX_PAGES) begin
         if (cur == pg) begin
            if (prev == NONE) free_head[r] = link_of[cur];
            else link_of[prev] = link_of[cur];
            return 1;
         end
         prev = cur;
         cur = link_of[cur];
         n++;
      end
      return 0;
   endfunction

   function automatic void rebuild_pool(int n);
      int r, m;
      r = 1;
      m = n;
      while (m > 1) begin
         m = m >> 1;
         r++;
      end
      if (r > 16) r = 16;
      pool_n = n;
      top_r = r;
      for (int i = 1; i <= 16; i++) free_head[i] = NONE;
      for (int i = 0; i < MAX_PAGES; i++) owner_rank[i] = 0;
      push_free(r, 0);
   endfunction

   function automatic alloc_reply_type predict_reply(logic [2:0] cmd, logic [4:0] rank_in,
                                                     logic [21:0] addr);
      alloc_reply_type o;
      int rk, pg, r, blk, cur, n;
      bit aligned;
      o.st = ST_INVALID;
      o.baddr = '0;
      o.value = '0;
      rk = rank_in;
      pg = addr >> PAGE_SHIFT;
      aligned = (addr[11:0] == 12'd0);
      case (cmd)
         CMD_RESTART: begin
            if (pages_cfg != 0) begin
               rebuild_pool(pages_cfg > MAX_PAGES ? MAX_PAGES : pages_cfg);
               o.st = ST_OK;
            end
         end
         CMD_ALLOC: begin
            if (rk >= 1 && rk <= 16) begin
               o.st = ST_NOSPACE;
               for (r = rk; r <= top_r; r++) begin
                  if (free_head[r] != NONE) begin
                     blk = free_head[r];
                     free_head[r] = link_of[blk];
                     while (r > rk) begin
                        push_free(r - 1, blk + span_of(r - 1));
                        r--;
                     end
                     owner_rank[blk] = rk;
                     o.baddr = 22'(blk << PAGE_SHIFT);
                     o.st = ST_OK;
                     break;
                  end
               end
            end
         end
         CMD_RETURN: begin
            if (aligned && owner_rank[pg] != 0) begin
               r = owner_rank[pg];
               owner_rank[pg] = 0;
               while (r < top_r && r < 16) begin
                  if (!unlink_free(r, pg ^ span_of(r))) break;
                  if ((pg ^ span_of(r)) < pg) pg = pg ^ span_of(r);
                  r++;
               end
               push_free(r, pg);
               o.st = ST_OK;
            end
         end
         CMD_QRANK: begin
            if (aligned && pg < pool_n) begin
               if (owner_rank[pg] != 0) begin
                  o.value = 11'(owner_rank[pg]);
                  o.st = ST_OK;
               end else begin
                  for (r = top_r; r >= 1 && o.st != ST_OK; r--) begin
                     cur = free_head[r];
                     n = 0;
                     while (cur >= 0 && cur < MAX_PAGES && n <= MAX_PAGES) begin
                        if (pg >= cur && pg - cur < span_of(r)) begin
                           o.value = 11'(r);
                           o.st = ST_OK;
                           break;
                        end
                        cur = link_of[cur];
                        n++;
                     end
                  end
               end
            end
         end
         CMD_QCOUNT: begin
            if (rk >= 1 && rk <= 16) begin
               cur = free_head[rk];
               n = 0;
               while (cur >= 0 && cur < MAX_PAGES && n < MAX_PAGES) begin
                  n++;
                  cur = link_of[cur];
               end
               o.value = 11'(n);
               o.st = ST_OK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // clock, reset and cycle limit
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (9) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %h", rsp_tdata);
            end else begin
               alloc_reply_type e;
               e = pending_replies.pop_front();
               if (rsp_tdata[1:0] !== e.st || rsp_tdata[23:2] !== e.baddr ||
                   rsp_tdata[34:24] !== e.value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch #%0d: exp st=%0d addr=%h val=%0d %s",
                              replies_seen, e.st, e.baddr, e.value,
                              $sformatf("got st=%0d addr=%h val=%0d", rsp_tdata[1:0],
                                        rsp_tdata[23:2], rsp_tdata[34:24]));
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // request side
   task automatic send_req(logic [2:0] cmd, logic [4:0] rk, logic [21:0] addr,
                           bit typed, alloc_reply_type typed_exp);
      alloc_reply_type p;
      int gap;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {2'b00, addr, rk, cmd};
      do @(posedge clock); while (!req_tready);
      p = predict_reply(cmd, rk, addr);
      pending_replies.push_back(typed ? typed_exp : p);
      if (p.st == ST_OK) begin
         if (cmd == CMD_RESTART) begin
            live_addrs.delete();
            n_restart++;
         end
         if (cmd == CMD_ALLOC) begin
            live_addrs.push_back(p.baddr);
            n_alloc_ok++;
         end
         if (cmd == CMD_RETURN) n_return_ok++;
      end
   endtask

   task automatic drain_and_set_pages(logic [10:0] pc);
      req_tvalid <= 0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= pc;
      @(posedge clock);
      csr_wr_en <= 0;
      pages_cfg = pc;
   endtask

   task automatic random_req();
      alloc_reply_type none;
      int pick, idx;
      logic [2:0] cmd;
      logic [4:0] rk;
      logic [21:0] addr;
      none = '{ST_OK, '0, '0};
      pick = $urandom_range(99);
      rk = 5'($urandom_range(1, 4));
      addr = 22'($urandom_range(pool_n - 1, 0) << PAGE_SHIFT);
      if ($urandom_range(9) == 0) rk = 5'($urandom_range(0, 31));
      if (pick < 3) begin
         cmd = CMD_RESTART;
      end else if (pick < 42) begin
         cmd = CMD_ALLOC;
      end else if (pick < 70) begin
         cmd = CMD_RETURN;
         if (live_addrs.size() != 0 && $urandom_range(99) < 85) begin
            idx = $urandom_range(live_addrs.size() - 1);
            addr = 22'(live_addrs[idx]);
            live_addrs.delete(idx);
         end else if ($urandom_range(1)) begin
            addr = 22'($urandom_range(22'h3FFFFF));
         end
      end else if (pick < 85) begin
         cmd = CMD_QRANK;
         if (live_addrs.size() != 0 && $urandom_range(1))
            addr = 22'(live_addrs[$urandom_range(live_addrs.size() - 1)]);
         else if ($urandom_range(3) == 0)
            addr = 22'($urandom_range(22'h3FFFFF));
      end else if (pick < 97) begin
         cmd = CMD_QCOUNT;
         rk = $urandom_range(1) ? 5'($urandom_range(1, top_r)) : 5'($urandom_range(0, 31));
      end else begin
         cmd = 3'($urandom_range(5, 7));
         addr = 22'($urandom_range(22'h3FFFFF));
         rk = 5'($urandom_range(0, 31));
      end
      send_req(cmd, rk, addr, 0, none);
   endtask

   step_row_type directed[$];
   int           pool_sizes[10] = '{1024, 1, 2047, 0, 37, 2, 1000, 512, 1023, 3};
   int           cfg_idx;

   initial begin
      alloc_reply_type none, ex;
      req_tvalid = 0;
      req_tdata = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      cfg_idx = 0;
      pages_cfg = PAGES_RESET;
      for (int i = 0; i < MAX_PAGES; i++) link_of[i] = 0;
      rebuild_pool(MAX_PAGES);
      none = '{ST_OK, '0, '0};

      directed = '{
         '{CMD_QCOUNT,  5'd11, 22'd0,       1, ST_OK,      '0, 11'd1},
         '{CMD_QCOUNT,  5'd0,  22'd0,       1, ST_INVALID, '0, '0},
         '{CMD_QCOUNT,  5'd17, 22'd0,       1, ST_INVALID, '0, '0},
         '{CMD_QCOUNT,  5'd31, 22'd0,       1, ST_INVALID, '0, '0},
         '{CMD_QCOUNT,  5'd16, 22'd0,       1, ST_OK,      '0, '0},
         '{CMD_QRANK,   5'd0,  22'd0,       1, ST_OK,      '0, 11'd11},
         '{CMD_QRANK,   5'd0,  22'd1,       1, ST_INVALID, '0, '0},
         '{CMD_ALLOC,   5'd0,  22'd0,       1, ST_INVALID, '0, '0},
         '{CMD_ALLOC,   5'd17, 22'd0,       1, ST_INVALID, '0, '0},
         '{CMD_ALLOC,   5'd31, 22'h3FFFFF,  1, ST_INVALID, '0, '0},
         '{CMD_ALLOC,   5'd12, 22'd0,       1, ST_NOSPACE, '0, '0},
         '{CMD_ALLOC,   5'd1,  22'd0,       1, ST_OK,      '0, '0},
         '{CMD_ALLOC,   5'd11, 22'd0,       1, ST_NOSPACE, '0, '0},
         '{CMD_RETURN,  5'd0,  22'd123,     1, ST_INVALID, '0, '0},
         '{CMD_RETURN,  5'd0,  22'h3FF000,  1, ST_INVALID, '0, '0},
         '{CMD_QRANK,   5'd0,  22'd0,       1, ST_OK,      '0, 11'd1},
         '{CMD_QRANK,   5'd0,  22'h001000,  0, ST_OK,      '0, '0},
         '{CMD_ALLOC,   5'd3,  22'd0,       0, ST_OK,      '0, '0},
         '{CMD_RETURN,  5'd0,  22'd0,       1, ST_OK,      '0, '0},
         '{3'd5,        5'd31, 22'h3FFFFF,  1, ST_INVALID, '0, '0},
         '{3'd6,        5'd0,  22'd0,       1, ST_INVALID, '0, '0},
         '{3'd7,        5'd1,  22'd0,       1, ST_INVALID, '0, '0},
         '{CMD_QRANK,   5'd0,  22'h3FFFFF,  1, ST_INVALID, '0, '0},
         '{CMD_RESTART, 5'd0,  22'd0,       1, ST_OK,      '0, '0},
         '{CMD_QCOUNT,  5'd11, 22'd0,       1, ST_OK,      '0, 11'd1}
      };

      tx_idle_pct = 33;
      rx_idle_pct = 60;
      @(negedge reset);
      @(posedge clock);
      foreach (directed[i]) begin
         ex = '{directed[i].st, directed[i].baddr, directed[i].value};
         send_req(directed[i].cmd, directed[i].rank, directed[i].addr,
                  directed[i].typed, ex);
      end

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 60 : 0;
         rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 33 : 0;
         for (int k = 0; k < 200; k++) begin
            if (k % 60 == 0) begin
               drain_and_set_pages(pool_sizes[cfg_idx % 10]);
               cfg_idx++;
               send_req(CMD_RESTART, 5'd0, 22'd0, 0, none);
            end
            random_req();
         end
      end

      req_tvalid <= 0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("%0d responses checked over %0d pool sizes:", replies_seen, cfg_idx);
      $display("%0d restarts, %0d allocations, %0d frees",
               n_restart, n_alloc_ok, n_return_ok);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
